// ===== sv/s5ch_pkg.sv =====
// Shared types and constants of the SOCKS5 client handshake unit.
`timescale 1ns / 1ps
`default_nettype none
package s5ch_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_USER  = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  localparam logic [3:0] ST_BUSY      = 4'd0;
  localparam logic [3:0] ST_CONNECTED = 4'd1;
  localparam logic [3:0] ST_REFUSED   = 4'd2;
  localparam logic [3:0] ST_DENIED    = 4'd3;
  localparam logic [3:0] ST_NO_PERM   = 4'd4;
  localparam logic [3:0] ST_NET_UNR   = 4'd5;
  localparam logic [3:0] ST_HOST_UNR  = 4'd6;
  localparam logic [3:0] ST_LINK_ERR  = 4'd7;
  localparam logic [3:0] ST_IDLE      = 4'd8;

  localparam logic [7:0] B_00 = 8'h00;
  localparam logic [7:0] B_01 = 8'h01;
  localparam logic [7:0] B_02 = 8'h02;
  localparam logic [7:0] B_03 = 8'h03;
  localparam logic [7:0] B_04 = 8'h04;
  localparam logic [7:0] B_05 = 8'h05;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GREET,
    OP_AUTH,
    OP_USER,
    OP_CONN
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        use_auth;
    logic        dest_is_v6;
    logic [63:0] dest_addr_hi;
    logic [63:0] dest_addr_lo;
    logic [15:0] dest_port;
    logic [7:0]  user_len;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    op_t         op;
    logic        flag;
    logic [7:0]  value;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic [3:0]  status;
    logic        want;
  } job_t;

endpackage
`default_nettype wire

// ===== sv/s5ch_front.sv =====
// Front part: tracks the handshake phase and turns each item into a send job.
`timescale 1ns / 1ps
`default_nettype none
module s5ch_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  s5ch_pkg::item_t    item,
  output s5ch_pkg::job_t     job
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_GREET, PH_USER, PH_AUTH, PH_HEAD, PH_ADDR, PH_HLEN, PH_PORT, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  skip_left, skip_left_next;
  logic [7:0]  user_left, user_left_next;
  logic        saved_auth, saved_auth_next;
  logic        saved_v6, saved_v6_next;
  logic [63:0] saved_addr_hi, saved_addr_hi_next;
  logic [63:0] saved_addr_lo, saved_addr_lo_next;
  logic [15:0] saved_port, saved_port_next;
  logic [3:0]  final_status, final_status_next;

  function automatic logic [3:0] pend(input logic [3:0] fs, input logic [3:0] code);
    return (fs == s5ch_pkg::ST_BUSY) ? code : fs;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [3:0] fs;
    logic [7:0] dec;
    logic       busy_next;
    b = item.data_byte;
    fs = final_status;
    dec = skip_left - 8'd1;
    phase_next = phase;
    byte_index_next = byte_index;
    skip_left_next = skip_left;
    user_left_next = user_left;
    saved_auth_next = saved_auth;
    saved_v6_next = saved_v6;
    saved_addr_hi_next = saved_addr_hi;
    saved_addr_lo_next = saved_addr_lo;
    saved_port_next = saved_port;
    final_status_next = final_status;
    job.op = s5ch_pkg::OP_NONE;
    job.flag = 1'b0;
    job.value = s5ch_pkg::B_00;
    job.addr_hi = saved_addr_hi;
    job.addr_lo = saved_addr_lo;
    job.port = saved_port;
    job.flag = 1'b0;
    unique case (item.kind)
      s5ch_pkg::KIND_START: begin
        saved_auth_next = item.use_auth;
        saved_v6_next = item.dest_is_v6;
        saved_addr_hi_next = item.dest_addr_hi;
        saved_addr_lo_next = item.dest_addr_lo;
        saved_port_next = item.dest_port;
        user_left_next = item.user_len;
        byte_index_next = 2'd0;
        skip_left_next = 8'd0;
        final_status_next = s5ch_pkg::ST_BUSY;
        phase_next = PH_GREET;
        job.op = s5ch_pkg::OP_GREET;
        job.flag = item.use_auth;
      end
      s5ch_pkg::KIND_REPLY: begin
        unique case (phase)
          PH_GREET: begin
            if (byte_index == 2'd0) begin
              if (b != s5ch_pkg::B_05) final_status_next = pend(fs, s5ch_pkg::ST_REFUSED);
              byte_index_next = 2'd1;
            end else begin
              if (b != (saved_auth ? s5ch_pkg::B_02 : s5ch_pkg::B_00)) begin
                fs = pend(fs, s5ch_pkg::ST_REFUSED);
              end
              final_status_next = fs;
              if (fs != s5ch_pkg::ST_BUSY) begin
                phase_next = PH_DONE;
              end else if (saved_auth) begin
                job.op = s5ch_pkg::OP_AUTH;
                job.value = user_left;
                job.flag = (user_left == 8'd0);
                if (user_left == 8'd0) begin
                  phase_next = PH_AUTH;
                  byte_index_next = 2'd0;
                end else begin
                  phase_next = PH_USER;
                end
              end else begin
                job.op = s5ch_pkg::OP_CONN;
                job.flag = saved_v6;
                byte_index_next = 2'd0;
                phase_next = PH_HEAD;
              end
            end
          end
          PH_AUTH: begin
            if (byte_index == 2'd0) begin
              if (b != s5ch_pkg::B_01) final_status_next = pend(fs, s5ch_pkg::ST_DENIED);
              byte_index_next = 2'd1;
            end else begin
              if (b != s5ch_pkg::B_00) fs = pend(fs, s5ch_pkg::ST_DENIED);
              final_status_next = fs;
              if (fs != s5ch_pkg::ST_BUSY) begin
                phase_next = PH_DONE;
              end else begin
                job.op = s5ch_pkg::OP_CONN;
                job.flag = saved_v6;
                byte_index_next = 2'd0;
                phase_next = PH_HEAD;
              end
            end
          end
          PH_HEAD: begin
            unique case (byte_index)
              2'd0: begin
                if (b != s5ch_pkg::B_05) final_status_next = pend(fs, s5ch_pkg::ST_REFUSED);
                byte_index_next = 2'd1;
              end
              2'd1: begin
                priority if (b == s5ch_pkg::B_02) begin
                  final_status_next = pend(fs, s5ch_pkg::ST_NO_PERM);
                end else if (b == s5ch_pkg::B_03) begin
                  final_status_next = pend(fs, s5ch_pkg::ST_NET_UNR);
                end else if (b == s5ch_pkg::B_04) begin
                  final_status_next = pend(fs, s5ch_pkg::ST_HOST_UNR);
                end else if (b != s5ch_pkg::B_00) begin
                  final_status_next = pend(fs, s5ch_pkg::ST_REFUSED);
                end else begin
                  final_status_next = fs;
                end
                byte_index_next = 2'd2;
              end
              2'd2: begin
                if (b != s5ch_pkg::B_00) final_status_next = pend(fs, s5ch_pkg::ST_REFUSED);
                byte_index_next = 2'd3;
              end
              2'd3: begin
                priority if (fs != s5ch_pkg::ST_BUSY) begin
                  phase_next = PH_DONE;
                end else if (b == s5ch_pkg::B_01) begin
                  phase_next = PH_ADDR;
                  skip_left_next = 8'd4;
                end else if (b == s5ch_pkg::B_04) begin
                  phase_next = PH_ADDR;
                  skip_left_next = 8'd16;
                end else if (b == s5ch_pkg::B_03) begin
                  phase_next = PH_HLEN;
                end else begin
                  final_status_next = s5ch_pkg::ST_REFUSED;
                  phase_next = PH_DONE;
                end
              end
              default: begin
              end
            endcase
          end
          PH_HLEN: begin
            if (b == s5ch_pkg::B_00) begin
              phase_next = PH_PORT;
              skip_left_next = 8'd2;
            end else begin
              phase_next = PH_ADDR;
              skip_left_next = b;
            end
          end
          PH_ADDR: begin
            if (dec == 8'd0) begin
              phase_next = PH_PORT;
              skip_left_next = 8'd2;
            end else begin
              skip_left_next = dec;
            end
          end
          PH_PORT: begin
            skip_left_next = dec;
            if (dec == 8'd0) begin
              final_status_next = s5ch_pkg::ST_CONNECTED;
              phase_next = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
      s5ch_pkg::KIND_USER: begin
        if (phase == PH_USER && user_left != 8'd0) begin
          job.op = s5ch_pkg::OP_USER;
          job.value = b;
          job.flag = (user_left == 8'd1);
          user_left_next = user_left - 8'd1;
          if (user_left == 8'd1) begin
            phase_next = PH_AUTH;
            byte_index_next = 2'd0;
          end
        end
      end
      s5ch_pkg::KIND_ABORT: begin
        if (phase != PH_IDLE && phase != PH_DONE) begin
          final_status_next = s5ch_pkg::ST_LINK_ERR;
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    busy_next = (phase_next != PH_IDLE) && (phase_next != PH_DONE);
    job.status = busy_next ? s5ch_pkg::ST_BUSY : final_status_next;
    job.want = (phase_next == PH_USER) && (user_left_next != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_index <= 2'd0;
      skip_left <= 8'd0;
      user_left <= 8'd0;
      saved_auth <= 1'b0;
      saved_v6 <= 1'b0;
      final_status <= s5ch_pkg::ST_IDLE;
    end else if (push) begin
      phase <= phase_next;
      byte_index <= byte_index_next;
      skip_left <= skip_left_next;
      user_left <= user_left_next;
      saved_auth <= saved_auth_next;
      saved_v6 <= saved_v6_next;
      final_status <= final_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      saved_addr_hi <= saved_addr_hi_next;
      saved_addr_lo <= saved_addr_lo_next;
      saved_port <= saved_port_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/s5ch_queue.sv =====
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module s5ch_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  s5ch_pkg::job_t   push_job,
  output logic             not_full,
  input  wire logic        pop,
  output logic             not_empty,
  output s5ch_pkg::job_t   head
);

  s5ch_pkg::job_t mem [s5ch_pkg::QDEPTH];
  logic [s5ch_pkg::QPTR_W-1:0] wr_ptr;
  logic [s5ch_pkg::QPTR_W-1:0] rd_ptr;
  logic [s5ch_pkg::QCNT_W-1:0] count;

  assign not_full = (count != s5ch_pkg::QCNT_W'(s5ch_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/s5ch_back.sv =====
// Back part: serializes queued jobs into result items through an output register.
`timescale 1ns / 1ps
`default_nettype none
module s5ch_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  s5ch_pkg::job_t   q_head,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  logic [4:0] idx;
  logic       o_valid;
  logic       o_tx_valid;
  logic [7:0] o_byte;
  logic       o_last;
  logic [3:0] o_status;
  logic       o_want;

  logic [4:0]   total;
  logic [7:0]   gen_byte;
  logic         gen_last;
  logic         load;
  logic [127:0] addr128;
  logic [4:0]   ak;
  logic [4:0]   n_addr;
  logic [6:0]   sel;

  always_comb begin
    addr128 = q_head.flag ? {q_head.addr_hi, q_head.addr_lo} : {q_head.addr_lo[31:0], 96'd0};
    ak = idx - 5'd4;
    n_addr = q_head.flag ? 5'd16 : 5'd4;
    sel = 7'd127 - {ak[3:0], 3'b000};
    total = 5'd1;
    gen_byte = s5ch_pkg::B_00;
    unique case (q_head.op)
      s5ch_pkg::OP_NONE: begin
        total = 5'd1;
      end
      s5ch_pkg::OP_GREET: begin
        total = 5'd3;
        unique case (idx)
          5'd0: gen_byte = s5ch_pkg::B_05;
          5'd1: gen_byte = s5ch_pkg::B_01;
          default: gen_byte = q_head.flag ? s5ch_pkg::B_02 : s5ch_pkg::B_00;
        endcase
      end
      s5ch_pkg::OP_AUTH: begin
        total = q_head.flag ? 5'd4 : 5'd2;
        unique case (idx)
          5'd0: gen_byte = s5ch_pkg::B_01;
          5'd1: gen_byte = q_head.value;
          5'd2: gen_byte = s5ch_pkg::B_01;
          default: gen_byte = s5ch_pkg::B_00;
        endcase
      end
      s5ch_pkg::OP_USER: begin
        total = q_head.flag ? 5'd3 : 5'd1;
        unique case (idx)
          5'd0: gen_byte = q_head.value;
          5'd1: gen_byte = s5ch_pkg::B_01;
          default: gen_byte = s5ch_pkg::B_00;
        endcase
      end
      s5ch_pkg::OP_CONN: begin
        total = q_head.flag ? 5'd22 : 5'd10;
        priority if (idx == 5'd0) begin
          gen_byte = s5ch_pkg::B_05;
        end else if (idx == 5'd1) begin
          gen_byte = s5ch_pkg::B_01;
        end else if (idx == 5'd2) begin
          gen_byte = s5ch_pkg::B_00;
        end else if (idx == 5'd3) begin
          gen_byte = q_head.flag ? s5ch_pkg::B_04 : s5ch_pkg::B_01;
        end else if (ak < n_addr) begin
          gen_byte = addr128[sel -: 8];
        end else if (ak == n_addr) begin
          gen_byte = q_head.port[15:8];
        end else begin
          gen_byte = q_head.port[7:0];
        end
      end
      default: begin
      end
    endcase
    gen_last = (idx == total - 5'd1);
  end

  assign load = q_valid && (!o_valid || m_tready);
  assign q_pop = load && gen_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 5'd0;
      o_valid <= 1'b0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
        idx <= gen_last ? 5'd0 : idx + 5'd1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_tx_valid <= (q_head.op != s5ch_pkg::OP_NONE);
      o_byte <= gen_byte;
      o_last <= gen_last;
      o_status <= q_head.status;
      o_want <= q_head.want;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata = {3'd0, o_want, o_status, o_byte};
  assign m_tlast = o_last;
  assign m_tuser = o_tx_valid;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst) idx < 5'd22)
    else $error("Result index out of range.");
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_tx_valid) |-> (o_last && o_byte == s5ch_pkg::B_00))
    else $error("An item without a send byte must be a lone zero result.");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (o_valid && o_last && idx == 5'd0))
    else $error("A job left the queue before its last result.");
`endif

endmodule
`default_nettype wire

// ===== sv/socks5_client_handshake_unit.sv =====
// Top level of the SOCKS5 client CONNECT handshake unit.
// The first result of an item reaches the output through the job queue and then the output register.
// Items are accepted one per cycle while the four-entry job queue has room.
// An item causes up to 22 results, and the output register holds each result
// for as long as m_tready is low.
// Reset (synchronous, active high) sets the phase to idle with status idle and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module socks5_client_handshake_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // use_auth[0], dest_is_v6[1], dest_addr_hi[65:2], dest_addr_lo[129:66],
  // dest_port[145:130], user_len[153:146], data_byte[161:154], zero fill above.
  input  wire logic [167:0] s_tdata,
  // kind[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // tx_byte[7:0], status[11:8], want_username[12], zero fill above.
  output logic [15:0]       m_tdata,
  output logic              m_tlast,
  // tx_valid[0]
  output logic              m_tuser
);

  s5ch_pkg::item_t item;
  s5ch_pkg::job_t  push_job;
  s5ch_pkg::job_t  head;
  logic            push;
  logic            not_full;
  logic            not_empty;
  logic            pop;

  always_comb begin
    item.kind = s_tuser;
    item.use_auth = s_tdata[0];
    item.dest_is_v6 = s_tdata[1];
    item.dest_addr_hi = s_tdata[65:2];
    item.dest_addr_lo = s_tdata[129:66];
    item.dest_port = s_tdata[145:130];
    item.user_len = s_tdata[153:146];
    item.data_byte = s_tdata[161:154];
  end

  assign s_tready = not_full;
  assign push = s_tvalid && not_full;

  s5ch_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .item (item),
    .job  (push_job)
  );

  s5ch_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  s5ch_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_head   (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

// ===== tb/tb_socks5_client_handshake_unit.sv =====
// Self-checking testbench for the SOCKS5 client handshake unit with a built-in predictor.
`timescale 1ns / 1ps
module tb_socks5_client_handshake_unit;

  localparam int WDOG_LIMIT = 2000;
  localparam int RAND_ITEMS = 100;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [3:0] {
    HS_IDLE, HS_GREET, HS_USER, HS_AUTH, HS_HEAD, HS_ADDR, HS_HLEN, HS_PORT, HS_DONE
  } hs_phase_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [3:0] status;
    logic       want;
  } tx_word_t;

  typedef struct {
    s5ch_pkg::item_t it;
    bit              typed;
    logic [3:0]      st;
  } dir_row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [1:0]   s_tuser = s5ch_pkg::KIND_REPLY;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic         m_tlast;
  logic         m_tuser;

  socks5_client_handshake_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  hs_phase_t   m_phase = HS_IDLE;
  logic [4:0]  m_idx = '0;
  logic [7:0]  m_skip = '0;
  logic [7:0]  m_user = '0;
  logic        m_auth = 1'b0;
  logic        m_v6 = 1'b0;
  logic [63:0] m_hi = '0;
  logic [63:0] m_lo = '0;
  logic [15:0] m_port = '0;
  logic [3:0]  m_status = s5ch_pkg::ST_IDLE;
  logic [7:0]  tx_bytes[$];
  tx_word_t    expected_tx[$];

  dir_row_t        dir_tab[$];
  s5ch_pkg::item_t plan[$];
  tx_word_t        got_w;
  tx_word_t        want_w;

  int items_in = 0;
  int results_seen = 0;
  int mism_cnt = 0;
  int connected_cnt = 0;
  int failed_cnt = 0;
  int idle_cnt = 0;
  int cyc = 0;
  int stall_left = 0;
  int rand_sent = 0;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void mark_fail(logic [3:0] code);
    if (m_status == s5ch_pkg::ST_BUSY) m_status = code;
  endfunction

  function automatic void close_hs(logic [3:0] code);
    m_status = code;
    m_phase = HS_DONE;
    if (code == s5ch_pkg::ST_CONNECTED) connected_cnt++;
    else failed_cnt++;
  endfunction

  function automatic void queue_connect();
    tx_bytes.push_back(s5ch_pkg::B_05);
    tx_bytes.push_back(s5ch_pkg::B_01);
    tx_bytes.push_back(s5ch_pkg::B_00);
    if (m_v6) begin
      tx_bytes.push_back(s5ch_pkg::B_04);
      for (int i = 7; i >= 0; i--) tx_bytes.push_back(m_hi[i*8 +: 8]);
      for (int i = 7; i >= 0; i--) tx_bytes.push_back(m_lo[i*8 +: 8]);
    end else begin
      tx_bytes.push_back(s5ch_pkg::B_01);
      for (int i = 3; i >= 0; i--) tx_bytes.push_back(m_lo[i*8 +: 8]);
    end
    tx_bytes.push_back(m_port[15:8]);
    tx_bytes.push_back(m_port[7:0]);
    m_idx = '0;
    m_phase = HS_HEAD;
  endfunction

  function automatic void take_reply(logic [7:0] b);
    case (m_phase)
      HS_GREET: begin
        if (m_idx == 0) begin
          if (b != s5ch_pkg::B_05) mark_fail(s5ch_pkg::ST_REFUSED);
          m_idx = 5'd1;
        end else begin
          if (b != (m_auth ? s5ch_pkg::B_02 : s5ch_pkg::B_00)) mark_fail(s5ch_pkg::ST_REFUSED);
          if (m_status != s5ch_pkg::ST_BUSY) close_hs(m_status);
          else if (m_auth) begin
            tx_bytes.push_back(s5ch_pkg::B_01);
            tx_bytes.push_back(m_user);
            if (m_user == 0) begin
              tx_bytes.push_back(s5ch_pkg::B_01);
              tx_bytes.push_back(s5ch_pkg::B_00);
              m_phase = HS_AUTH;
              m_idx = '0;
            end else begin
              m_phase = HS_USER;
            end
          end else begin
            queue_connect();
          end
        end
      end
      HS_AUTH: begin
        if (m_idx == 0) begin
          if (b != s5ch_pkg::B_01) mark_fail(s5ch_pkg::ST_DENIED);
          m_idx = 5'd1;
        end else begin
          if (b != s5ch_pkg::B_00) mark_fail(s5ch_pkg::ST_DENIED);
          if (m_status != s5ch_pkg::ST_BUSY) close_hs(m_status);
          else queue_connect();
        end
      end
      HS_HEAD: begin
        if (m_idx == 0) begin
          if (b != s5ch_pkg::B_05) mark_fail(s5ch_pkg::ST_REFUSED);
          m_idx = m_idx + 5'd1;
        end else if (m_idx == 1) begin
          case (b)
            s5ch_pkg::B_00: ;
            s5ch_pkg::B_02: mark_fail(s5ch_pkg::ST_NO_PERM);
            s5ch_pkg::B_03: mark_fail(s5ch_pkg::ST_NET_UNR);
            s5ch_pkg::B_04: mark_fail(s5ch_pkg::ST_HOST_UNR);
            default: mark_fail(s5ch_pkg::ST_REFUSED);
          endcase
          m_idx = m_idx + 5'd1;
        end else if (m_idx == 2) begin
          if (b != s5ch_pkg::B_00) mark_fail(s5ch_pkg::ST_REFUSED);
          m_idx = m_idx + 5'd1;
        end else if (m_status != s5ch_pkg::ST_BUSY) begin
          close_hs(m_status);
        end else begin
          case (b)
            s5ch_pkg::B_01: begin
              m_phase = HS_ADDR;
              m_skip = 8'd4;
            end
            s5ch_pkg::B_04: begin
              m_phase = HS_ADDR;
              m_skip = 8'd16;
            end
            s5ch_pkg::B_03: m_phase = HS_HLEN;
            default: close_hs(s5ch_pkg::ST_REFUSED);
          endcase
        end
      end
      HS_HLEN: begin
        if (b == 0) begin
          m_phase = HS_PORT;
          m_skip = 8'd2;
        end else begin
          m_phase = HS_ADDR;
          m_skip = b;
        end
      end
      HS_ADDR: begin
        m_skip = m_skip - 8'd1;
        if (m_skip == 0) begin
          m_phase = HS_PORT;
          m_skip = 8'd2;
        end
      end
      HS_PORT: begin
        m_skip = m_skip - 8'd1;
        if (m_skip == 0) close_hs(s5ch_pkg::ST_CONNECTED);
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_item(s5ch_pkg::item_t it, bit typed, logic [3:0] typed_st);
    bit         was_busy;
    logic [3:0] st;
    logic       want;
    tx_word_t   w;
    was_busy = (m_phase != HS_IDLE) && (m_phase != HS_DONE);
    tx_bytes.delete();
    case (it.kind)
      s5ch_pkg::KIND_START: begin
        m_auth = it.use_auth;
        m_v6 = it.dest_is_v6;
        m_hi = it.dest_addr_hi;
        m_lo = it.dest_addr_lo;
        m_port = it.dest_port;
        m_user = it.user_len;
        m_idx = '0;
        m_skip = '0;
        m_status = s5ch_pkg::ST_BUSY;
        m_phase = HS_GREET;
        tx_bytes.push_back(s5ch_pkg::B_05);
        tx_bytes.push_back(s5ch_pkg::B_01);
        tx_bytes.push_back(m_auth ? s5ch_pkg::B_02 : s5ch_pkg::B_00);
      end
      s5ch_pkg::KIND_REPLY: take_reply(it.data_byte);
      s5ch_pkg::KIND_USER: begin
        if (m_phase == HS_USER && m_user != 0) begin
          tx_bytes.push_back(it.data_byte);
          m_user = m_user - 8'd1;
          if (m_user == 0) begin
            tx_bytes.push_back(s5ch_pkg::B_01);
            tx_bytes.push_back(s5ch_pkg::B_00);
            m_phase = HS_AUTH;
            m_idx = '0;
          end
        end
      end
      default: if (was_busy) close_hs(s5ch_pkg::ST_LINK_ERR);
    endcase
    st = ((m_phase != HS_IDLE) && (m_phase != HS_DONE)) ? s5ch_pkg::ST_BUSY : m_status;
    if (typed) st = typed_st;
    want = (m_phase == HS_USER) && (m_user != 0);
    if (tx_bytes.size() == 0) begin
      w = '{tx_valid: 1'b0, tx_byte: 8'h00, last: 1'b1, status: st, want: want};
      expected_tx.push_back(w);
    end else begin
      foreach (tx_bytes[i]) begin
        w = '{tx_valid: 1'b1, tx_byte: tx_bytes[i], last: (i == tx_bytes.size() - 1),
              status: st, want: want};
        expected_tx.push_back(w);
      end
    end
  endfunction

  function automatic s5ch_pkg::item_t rand_item(logic [1:0] k, logic [7:0] d);
    s5ch_pkg::item_t it;
    it.kind = k;
    it.use_auth = 1'($urandom);
    it.dest_is_v6 = 1'($urandom);
    it.dest_addr_hi = {$urandom, $urandom};
    it.dest_addr_lo = {$urandom, $urandom};
    it.dest_port = 16'($urandom);
    it.user_len = 8'($urandom);
    it.data_byte = d;
    return it;
  endfunction

  function automatic logic [7:0] maybe_bad(logic [7:0] good);
    return ($urandom_range(0, 11) == 0) ? 8'($urandom) : good;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] k, logic a, logic v6, logic [63:0] hi,
                                       logic [63:0] lo, logic [15:0] p, logic [7:0] ul,
                                       logic [7:0] d, bit typed, logic [3:0] st);
    dir_row_t r;
    r.it = '{kind: k, use_auth: a, dest_is_v6: v6, dest_addr_hi: hi, dest_addr_lo: lo,
             dest_port: p, user_len: ul, data_byte: d};
    r.typed = typed;
    r.st = st;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic void plan_session();
    s5ch_pkg::item_t st;
    logic [7:0]      code;
    logic [7:0]      atyp;
    int              n;
    int              pos;
    st = rand_item(s5ch_pkg::KIND_START, 8'($urandom));
    if ($urandom_range(0, 15) == 0) st.user_len = 8'($urandom_range(4, 40));
    else st.user_len = 8'($urandom_range(0, 3));
    plan.push_back(st);
    plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, maybe_bad(s5ch_pkg::B_05)));
    plan.push_back(rand_item(s5ch_pkg::KIND_REPLY,
                             maybe_bad(st.use_auth ? s5ch_pkg::B_02 : s5ch_pkg::B_00)));
    if (st.use_auth) begin
      for (int i = 0; i < st.user_len; i++) begin
        plan.push_back(rand_item(s5ch_pkg::KIND_USER, 8'($urandom)));
        if ($urandom_range(0, 7) == 0)
          plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, 8'($urandom)));
      end
      plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, maybe_bad(s5ch_pkg::B_01)));
      plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, maybe_bad(s5ch_pkg::B_00)));
    end
    plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, maybe_bad(s5ch_pkg::B_05)));
    case ($urandom_range(0, 9))
      0: code = 8'($urandom_range(2, 4));
      1: code = 8'($urandom);
      default: code = s5ch_pkg::B_00;
    endcase
    plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, code));
    plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, maybe_bad(s5ch_pkg::B_00)));
    case ($urandom_range(0, 6))
      0, 1: atyp = s5ch_pkg::B_01;
      2, 3: atyp = s5ch_pkg::B_04;
      4, 5: atyp = s5ch_pkg::B_03;
      default: atyp = 8'($urandom);
    endcase
    plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, atyp));
    n = (atyp == s5ch_pkg::B_01) ? 4 : (atyp == s5ch_pkg::B_04) ? 16 : 0;
    if (atyp == s5ch_pkg::B_03) begin
      n = $urandom_range(0, 6);
      plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, 8'(n)));
    end
    for (int i = 0; i < n + 2; i++)
      plan.push_back(rand_item(s5ch_pkg::KIND_REPLY, 8'($urandom)));
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(1, plan.size());
      plan.insert(pos, rand_item(2'($urandom), 8'($urandom)));
    end
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, plan.size());
      while (plan.size() > n) void'(plan.pop_back());
    end
  endfunction

  task automatic send_item(s5ch_pkg::item_t it, bit typed, logic [3:0] typed_st);
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, it.data_byte, it.user_len, it.dest_port, it.dest_addr_lo,
                it.dest_addr_hi, it.dest_is_v6, it.use_auth};
    s_tuser <= it.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(it, typed, typed_st);
    items_in++;
  endtask

  task automatic pause_sender(int cycles, bit drain);
    if (cycles > 0 || drain) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (expected_tx.size() != 0);
      end
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ((cyc % 512) < 128 || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got_w = '{tx_valid: m_tuser, tx_byte: m_tdata[7:0], last: m_tlast,
                status: m_tdata[11:8], want: m_tdata[12]};
      if (expected_tx.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("%0t: unexpected result txv=%b byte=%h last=%b st=%0d want=%b", $realtime,
                   got_w.tx_valid, got_w.tx_byte, got_w.last, got_w.status, got_w.want);
      end else begin
        want_w = expected_tx.pop_front();
        if (got_w !== want_w) begin
          mism_cnt++;
          if (mism_cnt <= 10) begin
            $display("%0t: mismatch exp txv=%b byte=%h last=%b st=%0d want=%b",
                     $realtime, want_w.tx_valid, want_w.tx_byte, want_w.last, want_w.status,
                     want_w.want);
            $display("    got txv=%b byte=%h last=%b st=%0d want=%b",
                     got_w.tx_valid, got_w.tx_byte, got_w.last, got_w.status, got_w.want);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_05,
                              1, s5ch_pkg::ST_IDLE));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_ABORT, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              1, s5ch_pkg::ST_IDLE));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_USER, 0, 0, 0, 0, 0, 0, 8'hff,
                              1, s5ch_pkg::ST_IDLE));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_START, 1, 0, 0, 0, 0, 8'hff, s5ch_pkg::B_00,
                              1, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_START, 0, 0, '1, '1, 16'hffff, 0, 8'hff,
                              1, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_05,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_05,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_03,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, 8'hff,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              1, s5ch_pkg::ST_CONNECTED));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_START, 1, 1, '1, 0, 0, 0, s5ch_pkg::B_00,
                              1, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_05,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_02,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_01,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_05,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_03,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              0, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_REPLY, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_01,
                              1, s5ch_pkg::ST_NET_UNR));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_START, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              1, s5ch_pkg::ST_BUSY));
    dir_tab.push_back(dir_row(s5ch_pkg::KIND_ABORT, 0, 0, 0, 0, 0, 0, s5ch_pkg::B_00,
                              1, s5ch_pkg::ST_LINK_ERR));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].st);
      pause_sender((i == dir_tab.size() - 1) ? 0 : pick_gap(), i == dir_tab.size() - 1);
    end

    while (rand_sent < RAND_ITEMS) begin
      plan.delete();
      plan_session();
      quiet = ($urandom_range(0, 3) == 0);
      foreach (plan[i]) begin
        send_item(plan[i], 1'b0, s5ch_pkg::ST_BUSY);
        rand_sent++;
        if (i == plan.size() - 1)
          pause_sender(quiet ? 0 : pick_gap(),
                       rand_sent >= RAND_ITEMS || $urandom_range(0, 4) == 0);
        else
          pause_sender(quiet ? 0 : pick_gap(), 1'b0);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drove %0d items and checked %0d results with random gaps and stalls.",
             items_in, results_seen);
    $display("Handshakes ended: %0d connected, %0d with an error or cancel; %0d mismatches.",
             connected_cnt, failed_cnt, mism_cnt);
    if (mism_cnt == 0 && expected_tx.size() == 0) begin
      $display("PASS");
    end else begin
      if (expected_tx.size() != 0)
        $display("%0d expected results never arrived", expected_tx.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
